FILE: rtl/hsv_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB package
// Shared constants for the HSV to RGB colour conversion pipeline.
// ----------------------------------------------------------------------------
package hsv_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int PIPE_DEPTH        = 4;

    typedef logic [2:0] sector_t;

    localparam sector_t SECT_RED_YELLOW    = 3'd0;
    localparam sector_t SECT_YELLOW_GREEN  = 3'd1;
    localparam sector_t SECT_GREEN_CYAN    = 3'd2;
    localparam sector_t SECT_CYAN_BLUE     = 3'd3;
    localparam sector_t SECT_BLUE_MAGENTA  = 3'd4;

endpackage

FILE: rtl/hsv_prep.sv
// ----------------------------------------------------------------------------
// HSV input stage
// Clamps saturation and value, splits six times the hue into sector and ramp.
// ----------------------------------------------------------------------------
module hsv_prep #(
    parameter int FRAC_BITS = hsv_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [FRAC_BITS-1:0]  hue,
    input  logic [FRAC_BITS:0]    saturation,
    input  logic [FRAC_BITS:0]    brightness,
    output logic                  out_valid,
    output hsv_pkg::sector_t      sector,
    output logic [FRAC_BITS:0]    ramp,
    output logic [FRAC_BITS:0]    sat,
    output logic [FRAC_BITS:0]    val
);
    import hsv_pkg::*;

    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic                 valid_reg;
    sector_t              sector_reg, sector_next;
    logic [FRAC_BITS:0]   ramp_reg, ramp_next;
    logic [FRAC_BITS:0]   sat_reg, sat_next;
    logic [FRAC_BITS:0]   val_reg, val_next;
    logic [FRAC_BITS+2:0] hue_wide;
    logic [FRAC_BITS+2:0] h6;
    logic [FRAC_BITS-1:0] frac;

    always_comb
    begin
        hue_wide    = {3'b000, hue};
        h6          = (hue_wide << 2) + (hue_wide << 1);
        sector_next = h6[FRAC_BITS+2:FRAC_BITS];
        frac        = h6[FRAC_BITS-1:0];
        ramp_next   = sector_next[0] ? (ONE - {1'b0, frac}) : {1'b0, frac};
        sat_next    = (saturation > ONE) ? ONE : saturation;
        val_next    = (brightness > ONE) ? ONE : brightness;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        sector_reg <= sector_next;
        ramp_reg   <= ramp_next;
        sat_reg    <= sat_next;
        val_reg    <= val_next;
    end

    assign out_valid = valid_reg;
    assign sector    = sector_reg;
    assign ramp      = ramp_reg;
    assign sat       = sat_reg;
    assign val       = val_reg;

endmodule

FILE: rtl/hsv_chroma.sv
// ----------------------------------------------------------------------------
// HSV chroma stage
// Multiplies value by saturation to form the chroma.
// ----------------------------------------------------------------------------
module hsv_chroma #(
    parameter int FRAC_BITS = hsv_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  hsv_pkg::sector_t     in_sector,
    input  logic [FRAC_BITS:0]   in_ramp,
    input  logic [FRAC_BITS:0]   sat,
    input  logic [FRAC_BITS:0]   val,
    output logic                 out_valid,
    output hsv_pkg::sector_t     out_sector,
    output logic [FRAC_BITS:0]   out_ramp,
    output logic [FRAC_BITS:0]   out_val,
    output logic [FRAC_BITS:0]   chroma
);
    import hsv_pkg::*;

    logic                   valid_reg;
    sector_t                sector_reg;
    logic [FRAC_BITS:0]     ramp_reg;
    logic [FRAC_BITS:0]     val_reg;
    logic [FRAC_BITS:0]     chroma_reg, chroma_next;
    logic [2*FRAC_BITS+1:0] product;

    always_comb
    begin
        product     = (2*FRAC_BITS+2)'(val) * (2*FRAC_BITS+2)'(sat);
        chroma_next = product[2*FRAC_BITS:FRAC_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        sector_reg <= in_sector;
        ramp_reg   <= in_ramp;
        val_reg    <= val;
        chroma_reg <= chroma_next;
    end

    assign out_valid  = valid_reg;
    assign out_sector = sector_reg;
    assign out_ramp   = ramp_reg;
    assign out_val    = val_reg;
    assign chroma     = chroma_reg;

endmodule

FILE: rtl/hsv_ramp.sv
// ----------------------------------------------------------------------------
// HSV ramp stage
// Scales the chroma by the hue ramp and forms the common base level.
// ----------------------------------------------------------------------------
module hsv_ramp #(
    parameter int FRAC_BITS = hsv_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  hsv_pkg::sector_t     in_sector,
    input  logic [FRAC_BITS:0]   ramp,
    input  logic [FRAC_BITS:0]   val,
    input  logic [FRAC_BITS:0]   in_chroma,
    output logic                 out_valid,
    output hsv_pkg::sector_t     out_sector,
    output logic [FRAC_BITS:0]   out_chroma,
    output logic [FRAC_BITS:0]   x,
    output logic [FRAC_BITS:0]   base
);
    import hsv_pkg::*;

    logic                   valid_reg;
    sector_t                sector_reg;
    logic [FRAC_BITS:0]     chroma_reg;
    logic [FRAC_BITS:0]     x_reg, x_next;
    logic [FRAC_BITS:0]     base_reg, base_next;
    logic [2*FRAC_BITS+1:0] product;

    always_comb
    begin
        product   = (2*FRAC_BITS+2)'(in_chroma) * (2*FRAC_BITS+2)'(ramp);
        x_next    = product[2*FRAC_BITS:FRAC_BITS];
        base_next = val - in_chroma;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        sector_reg <= in_sector;
        chroma_reg <= in_chroma;
        x_reg      <= x_next;
        base_reg   <= base_next;
    end

    assign out_valid  = valid_reg;
    assign out_sector = sector_reg;
    assign out_chroma = chroma_reg;
    assign x          = x_reg;
    assign base       = base_reg;

endmodule

FILE: rtl/hsv_mix.sv
// ----------------------------------------------------------------------------
// HSV channel mix stage
// Adds chroma and scaled ramp x to the base level of the selected channels.
// ----------------------------------------------------------------------------
module hsv_mix #(
    parameter int FRAC_BITS = hsv_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  hsv_pkg::sector_t     sector,
    input  logic [FRAC_BITS:0]   chroma,
    input  logic [FRAC_BITS:0]   x,
    input  logic [FRAC_BITS:0]   base,
    output logic                 out_valid,
    output logic [FRAC_BITS:0]   red,
    output logic [FRAC_BITS:0]   green,
    output logic [FRAC_BITS:0]   blue
);
    import hsv_pkg::*;

    logic               valid_reg;
    logic [FRAC_BITS:0] red_reg, red_next;
    logic [FRAC_BITS:0] green_reg, green_next;
    logic [FRAC_BITS:0] blue_reg, blue_next;

    always_comb
    begin
        red_next   = base;
        green_next = base;
        blue_next  = base;
        unique case (sector)
            SECT_RED_YELLOW:
            begin
                red_next   = base + chroma;
                green_next = base + x;
            end
            SECT_YELLOW_GREEN:
            begin
                red_next   = base + x;
                green_next = base + chroma;
            end
            SECT_GREEN_CYAN:
            begin
                green_next = base + chroma;
                blue_next  = base + x;
            end
            SECT_CYAN_BLUE:
            begin
                green_next = base + x;
                blue_next  = base + chroma;
            end
            SECT_BLUE_MAGENTA:
            begin
                red_next   = base + x;
                blue_next  = base + chroma;
            end
            default:
            begin
                red_next   = base + chroma;
                blue_next  = base + x;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
    end

    assign out_valid = valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

FILE: rtl/hsv_to_rgb_convert.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Four-stage pipeline converting one pixel from hue, saturation and value to
// red, green and blue.
// ----------------------------------------------------------------------------
// A pixel is taken at every clock edge at which start is high; busy is always
// low, so a new pixel may follow in every cycle. Each result beat appears on
// red, green and blue with done high for one cycle, in the order the pixels
// arrived, once its pixel has passed the four register stages: input clamping
// and hue split, the value times saturation multiplier, the chroma times ramp
// multiplier, and the channel mix. The receiver cannot stall the pipeline and
// must take every beat as it appears.
module hsv_to_rgb_convert #(
    parameter int FRAC_BITS = hsv_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [FRAC_BITS-1:0] hue,
    input  logic [FRAC_BITS:0]   saturation,
    input  logic [FRAC_BITS:0]   brightness,
    output logic                 done,
    output logic [FRAC_BITS:0]   red,
    output logic [FRAC_BITS:0]   green,
    output logic [FRAC_BITS:0]   blue
);
    import hsv_pkg::*;

    logic               s1_valid, s2_valid, s3_valid;
    sector_t            s1_sector, s2_sector, s3_sector;
    logic [FRAC_BITS:0] s1_ramp, s1_sat, s1_val;
    logic [FRAC_BITS:0] s2_ramp, s2_val, s2_chroma;
    logic [FRAC_BITS:0] s3_chroma, s3_x, s3_base;

    assign busy = 1'b0;

    hsv_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .out_valid  (s1_valid),
        .sector     (s1_sector),
        .ramp       (s1_ramp),
        .sat        (s1_sat),
        .val        (s1_val)
    );

    hsv_chroma #(.FRAC_BITS(FRAC_BITS)) u_chroma (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s1_valid),
        .in_sector  (s1_sector),
        .in_ramp    (s1_ramp),
        .sat        (s1_sat),
        .val        (s1_val),
        .out_valid  (s2_valid),
        .out_sector (s2_sector),
        .out_ramp   (s2_ramp),
        .out_val    (s2_val),
        .chroma     (s2_chroma)
    );

    hsv_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s2_valid),
        .in_sector  (s2_sector),
        .ramp       (s2_ramp),
        .val        (s2_val),
        .in_chroma  (s2_chroma),
        .out_valid  (s3_valid),
        .out_sector (s3_sector),
        .out_chroma (s3_chroma),
        .x          (s3_x),
        .base       (s3_base)
    );

    hsv_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid),
        .sector    (s3_sector),
        .chroma    (s3_chroma),
        .x         (s3_x),
        .base      (s3_base),
        .out_valid (done),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

endmodule

FILE: rtl/hsv_checker.sv
// ----------------------------------------------------------------------------
// HSV to RGB port checker
// Checks latency, range and grey and black behaviour seen at the ports.
// ----------------------------------------------------------------------------
module hsv_checker #(
    parameter int FRAC_BITS = hsv_pkg::FRAC_BITS_DEFAULT
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic [FRAC_BITS:0]   saturation,
    input logic [FRAC_BITS:0]   brightness,
    input logic                 done,
    input logic [FRAC_BITS:0]   red,
    input logic [FRAC_BITS:0]   green,
    input logic [FRAC_BITS:0]   blue
);
    import hsv_pkg::*;

    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_DEPTH done)
        else $error("result beat missing after accepted pixel");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##PIPE_DEPTH !done)
        else $error("result beat without accepted pixel");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (red <= ONE && green <= ONE && blue <= ONE))
        else $error("channel above one");

    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && brightness == '0) |->
            ##PIPE_DEPTH (red == '0 && green == '0 && blue == '0))
        else $error("zero value must give black");

    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && saturation == '0) |->
            ##PIPE_DEPTH (red == green && green == blue))
        else $error("zero saturation must give grey");

endmodule

bind hsv_to_rgb_convert hsv_checker #(.FRAC_BITS(FRAC_BITS)) u_hsv_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .saturation (saturation),
    .brightness (brightness),
    .done       (done),
    .red        (red),
    .green      (green),
    .blue       (blue)
);

FILE: bench/hsv_to_rgb_convert_check.sv
// ----------------------------------------------------------------------------
// HSV to RGB result checker
// Watches the pixel and result channels of the converter, works out the
// expected colour of every accepted pixel and compares each result beat with
// the oldest colour still outstanding.
// ----------------------------------------------------------------------------
module hsv_to_rgb_convert_check #(
    parameter int FRAC_BITS = hsv_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic [FRAC_BITS-1:0] hue,
    input  logic [FRAC_BITS:0]   saturation,
    input  logic [FRAC_BITS:0]   brightness,
    input  logic                 done,
    input  logic [FRAC_BITS:0]   red,
    input  logic [FRAC_BITS:0]   green,
    input  logic [FRAC_BITS:0]   blue,
    output int                   errors,
    output int                   pending,
    output int                   checked
);

    import hsv_pkg::*;

    localparam logic [63:0] ONE_FX = 64'd1 << FRAC_BITS;

    typedef struct packed {
        logic [FRAC_BITS:0] r;
        logic [FRAC_BITS:0] g;
        logic [FRAC_BITS:0] b;
    } rgb_t;

    rgb_t rgb_due[$];
    rgb_t want;
    int   faults;

    function automatic rgb_t predict_rgb(input logic [FRAC_BITS-1:0] h_in,
                                         input logic [FRAC_BITS:0]   s_in,
                                         input logic [FRAC_BITS:0]   v_in);
        logic [63:0] s;
        logic [63:0] v;
        logic [63:0] c;
        logic [63:0] h6;
        logic [63:0] frac;
        logic [63:0] ramp;
        logic [63:0] x;
        logic [63:0] base;
        logic [63:0] r;
        logic [63:0] g;
        logic [63:0] b;
        sector_t     sect;
        rgb_t        res;
        s    = (64'(s_in) > ONE_FX) ? ONE_FX : 64'(s_in);
        v    = (64'(v_in) > ONE_FX) ? ONE_FX : 64'(v_in);
        c    = (v * s) >> FRAC_BITS;
        h6   = 64'(h_in) * 64'd6;
        sect = sector_t'(h6 >> FRAC_BITS);
        frac = h6 & (ONE_FX - 64'd1);
        ramp = sect[0] ? (ONE_FX - frac) : frac;
        x    = (c * ramp) >> FRAC_BITS;
        base = v - c;
        r    = base;
        g    = base;
        b    = base;
        case (sect)
            SECT_RED_YELLOW:
            begin
                r = r + c;
                g = g + x;
            end
            SECT_YELLOW_GREEN:
            begin
                r = r + x;
                g = g + c;
            end
            SECT_GREEN_CYAN:
            begin
                g = g + c;
                b = b + x;
            end
            SECT_CYAN_BLUE:
            begin
                g = g + x;
                b = b + c;
            end
            SECT_BLUE_MAGENTA:
            begin
                r = r + x;
                b = b + c;
            end
            default:
            begin
                r = r + c;
                b = b + x;
            end
        endcase
        res.r = r[FRAC_BITS:0];
        res.g = g[FRAC_BITS:0];
        res.b = b[FRAC_BITS:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rgb_due.delete();
            errors  <= 0;
            pending <= 0;
            checked <= 0;
        end
        else
        begin
            faults = 0;
            if (start && !busy)
            begin
                rgb_due.push_back(predict_rgb(hue, saturation, brightness));
            end
            if (done !== 1'b0)
            begin
                if (rgb_due.size() == 0)
                begin
                    $display("%0t: result beat with no pixel outstanding: expected none, got %h %h %h",
                             $time, red, green, blue);
                    faults++;
                end
                else
                begin
                    want = rgb_due.pop_front();
                    if (red !== want.r)
                    begin
                        $display("%0t: red mismatch: expected %h, got %h", $time, want.r, red);
                        faults++;
                    end
                    if (green !== want.g)
                    begin
                        $display("%0t: green mismatch: expected %h, got %h", $time, want.g, green);
                        faults++;
                    end
                    if (blue !== want.b)
                    begin
                        $display("%0t: blue mismatch: expected %h, got %h", $time, want.b, blue);
                        faults++;
                    end
                    checked <= checked + 1;
                end
            end
            errors  <= errors + faults;
            pending <= rgb_due.size();
        end
    end

endmodule

FILE: bench/hsv_to_rgb_convert_test.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives directed and random pixels into the converter under several pacing
// schemes and leaves prediction and comparison to the checker beside it.
// ----------------------------------------------------------------------------
module hsv_to_rgb_convert_test;

    import hsv_pkg::*;

    localparam int FRAC_BITS = FRAC_BITS_DEFAULT;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int PHASE_LEN = 375;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [FRAC_BITS-1:0] hue;
    logic [FRAC_BITS:0]   saturation;
    logic [FRAC_BITS:0]   brightness;
    logic                 done;
    logic [FRAC_BITS:0]   red;
    logic [FRAC_BITS:0]   green;
    logic [FRAC_BITS:0]   blue;

    int errors;
    int pending;
    int checked;
    int pixels_sent;

    hsv_to_rgb_convert #(.FRAC_BITS(FRAC_BITS)) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .done       (done),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    hsv_to_rgb_convert_check #(.FRAC_BITS(FRAC_BITS)) u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .done       (done),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .errors     (errors),
        .pending    (pending),
        .checked    (checked)
    );

    always #5 clk = ~clk;

    task automatic send_pixel(input logic [FRAC_BITS-1:0] h,
                              input logic [FRAC_BITS:0]   s,
                              input logic [FRAC_BITS:0]   v);
        start      <= 1'b1;
        hue        <= h;
        saturation <= s;
        brightness <= v;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        pixels_sent++;
    endtask

    task automatic idle_cycle();
        start      <= 1'b0;
        hue        <= FRAC_BITS'($urandom);
        saturation <= (FRAC_BITS + 1)'($urandom);
        brightness <= (FRAC_BITS + 1)'($urandom);
        @(posedge clk);
    endtask

    function automatic logic [FRAC_BITS:0] pick_level();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            return (FRAC_BITS + 1)'($urandom_range(ONE));
        end
        else if (pick < 90)
        begin
            return (FRAC_BITS + 1)'($urandom);
        end
        else
        begin
            case ($urandom_range(3))
                0:       return '0;
                1:       return (FRAC_BITS + 1)'(ONE);
                2:       return (FRAC_BITS + 1)'(ONE + 1);
                default: return '1;
            endcase
        end
    endfunction

    task automatic send_random(input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            idle_cycle();
        end
        send_pixel(FRAC_BITS'($urandom), pick_level(), pick_level());
    endtask

    initial
    begin
        int idle_pct [4];
        int pct;
        idle_pct    = '{0, 69, 12, 0};
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        hue         = '0;
        saturation  = '0;
        brightness  = '0;
        pixels_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Hue at zero, at the top and on both sides of every sector boundary.
        send_pixel(16'd0,     17'd65536,  17'd65536);
        send_pixel(16'd65535, 17'd65536,  17'd65536);
        send_pixel(16'd10922, 17'd65536,  17'd65536);
        send_pixel(16'd10923, 17'd65536,  17'd65536);
        send_pixel(16'd21845, 17'd65536,  17'd65536);
        send_pixel(16'd21846, 17'd65536,  17'd65536);
        send_pixel(16'd32767, 17'd65536,  17'd65536);
        send_pixel(16'd32768, 17'd65536,  17'd65536);
        send_pixel(16'd43690, 17'd65536,  17'd65536);
        send_pixel(16'd43691, 17'd65536,  17'd65536);
        send_pixel(16'd54613, 17'd65536,  17'd65536);
        send_pixel(16'd54614, 17'd65536,  17'd65536);
        // Grey, black and saturation or brightness beyond one, which clamp.
        send_pixel(16'd30000, 17'd0,      17'd40000);
        send_pixel(16'd30000, 17'd50000,  17'd0);
        send_pixel(16'd5000,  17'd65537,  17'd50000);
        send_pixel(16'd5000,  17'd131071, 17'd50000);
        send_pixel(16'd50000, 17'd40000,  17'd65537);
        send_pixel(16'd50000, 17'd40000,  17'd131071);
        send_pixel(16'd65535, 17'd131071, 17'd131071);
        send_pixel(16'd21845, 17'd1,      17'd1);
        send_pixel(16'd1,     17'd65535,  17'd65535);
        send_pixel(16'd43690, 17'd65536,  17'd1);

        for (int phase = 0; phase < 4; phase++)
        begin
            for (int i = 0; i < PHASE_LEN; i++)
            begin
                // Every fourth run of forty pixels goes back to back.
                pct = ((i / 40) % 4 == 3) ? 0 : idle_pct[phase];
                send_random(pct);
            end
        end
        start <= 1'b0;
        @(posedge clk);

        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (2 * PIPE_DEPTH) @(posedge clk);

        $display("Drove %0d pixels across all six hue sectors, clamped levels and four pacing phases;",
                 pixels_sent);
        $display("%0d result beats compared against the predicted colours.", checked);
        if (errors == 0 && pending == 0)
        begin
            $display("[hsv_to_rgb_convert] OK");
        end
        else
        begin
            $display("[hsv_to_rgb_convert] ERROR");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("[hsv_to_rgb_convert] ERROR");
        $finish;
    end

endmodule

FILE: hsv_to_rgb_convert.f
rtl/hsv_pkg.sv
rtl/hsv_prep.sv
rtl/hsv_chroma.sv
rtl/hsv_ramp.sv
rtl/hsv_mix.sv
rtl/hsv_to_rgb_convert.sv
rtl/hsv_checker.sv
bench/hsv_to_rgb_convert_check.sv
bench/hsv_to_rgb_convert_test.sv
